// ===== rtl/ddl_token_scanner_top_defines.svh =====
// assertion macros shared by the checker
`ifndef DDL_TOKEN_SCANNER_TOP_DEFINES_SVH
`define DDL_TOKEN_SCANNER_TOP_DEFINES_SVH

// checked only outside reset
`define DDL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define DDL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ddl_pkg.sv =====
`timescale 1ns / 1ps
package ddl_pkg;

   localparam int MaxReservedLen = 16;
   localparam logic [7:0] SepReset = 8'd95;
   localparam logic [23:0] LenMax = 24'hFFFFFF;

   localparam logic [5:0] K_ERROR   = 6'd0;
   localparam logic [5:0] K_EOF     = 6'd1;
   localparam logic [5:0] K_LPAREN  = 6'd2;
   localparam logic [5:0] K_RPAREN  = 6'd3;
   localparam logic [5:0] K_LBRACE  = 6'd4;
   localparam logic [5:0] K_RBRACE  = 6'd5;
   localparam logic [5:0] K_LBRACK  = 6'd6;
   localparam logic [5:0] K_RBRACK  = 6'd7;
   localparam logic [5:0] K_EQUALS  = 6'd8;
   localparam logic [5:0] K_STAR    = 6'd9;
   localparam logic [5:0] K_COMMA   = 6'd10;
   localparam logic [5:0] K_PLUS    = 6'd11;
   localparam logic [5:0] K_MINUS   = 6'd12;
   localparam logic [5:0] K_NAME    = 6'd13;
   localparam logic [5:0] K_PATH    = 6'd14;
   localparam logic [5:0] K_CHAR    = 6'd15;
   localparam logic [5:0] K_STRING  = 6'd16;
   localparam logic [5:0] K_HEX     = 6'd17;
   localparam logic [5:0] K_BIN     = 6'd18;
   localparam logic [5:0] K_OCT     = 6'd19;
   localparam logic [5:0] K_FLOAT   = 6'd20;
   localparam logic [5:0] K_DEC     = 6'd21;
   localparam logic [5:0] K_IDENT   = 6'd22;
   localparam logic [5:0] K_BOOL    = 6'd23;
   localparam logic [5:0] K_INT8    = 6'd24;
   localparam logic [5:0] K_INT16   = 6'd25;
   localparam logic [5:0] K_INT32   = 6'd26;
   localparam logic [5:0] K_INT64   = 6'd27;
   localparam logic [5:0] K_UINT8   = 6'd28;
   localparam logic [5:0] K_UINT16  = 6'd29;
   localparam logic [5:0] K_UINT32  = 6'd30;
   localparam logic [5:0] K_UINT64  = 6'd31;
   localparam logic [5:0] K_FLOAT32 = 6'd32;
   localparam logic [5:0] K_FLOAT64 = 6'd33;
   localparam logic [5:0] K_STRTYPE = 6'd34;
   localparam logic [5:0] K_REF     = 6'd35;
   localparam logic [5:0] K_TYPEKW  = 6'd36;
   localparam logic [5:0] K_TRUE    = 6'd37;
   localparam logic [5:0] K_FALSE   = 6'd38;
   localparam logic [5:0] K_NULL    = 6'd39;
   localparam logic [5:0] K_LAST    = K_NULL;

   localparam logic [3:0] F_PATH     = 4'd1;
   localparam logic [3:0] F_NONEMPTY = 4'd2;
   localparam logic [3:0] F_ESC      = 4'd4;
   localparam logic [3:0] F_STAR     = 4'd8;

   localparam int NumWords = 39;
   localparam int WordBytes = 14;

   localparam logic [3:0] WordLen [NumWords] = '{
      4'd4, 4'd1, 4'd4, 4'd2, 4'd5, 4'd3, 4'd5, 4'd3, 4'd5, 4'd3,
      4'd5, 4'd2, 4'd13, 4'd6, 4'd3, 4'd14, 4'd6, 4'd3, 4'd14,
      4'd6, 4'd3, 4'd14, 4'd3, 4'd7, 4'd5, 4'd1, 4'd3, 4'd7, 4'd6, 4'd1,
      4'd6, 4'd1, 4'd3, 4'd1, 4'd4, 4'd1, 4'd4, 4'd5, 4'd4};

   localparam logic [5:0] WordKind [NumWords] = '{
      K_BOOL, K_BOOL, K_INT8, K_INT8, K_INT16, K_INT16, K_INT32, K_INT32,
      K_INT64, K_INT64, K_UINT8, K_UINT8, K_UINT8, K_UINT16, K_UINT16, K_UINT16,
      K_UINT32, K_UINT32, K_UINT32, K_UINT64, K_UINT64, K_UINT64,
      K_FLOAT32, K_FLOAT32, K_FLOAT32, K_FLOAT32,
      K_FLOAT64, K_FLOAT64, K_FLOAT64, K_FLOAT64,
      K_STRTYPE, K_STRTYPE, K_REF, K_REF, K_TYPEKW, K_TYPEKW,
      K_TRUE, K_FALSE, K_NULL};

   // right aligned: first character in the highest used byte
   localparam logic [8*WordBytes-1:0] WordText [NumWords] = '{
      "bool", "b", "int8", "i8", "int16", "i16", "int32", "i32", "int64", "i64",
      "uint8", "u8", {"unsigned_", "int8"}, "uint16", "u16", {"unsigned_", "int16"},
      "uint32", "u32", {"unsigned_", "int32"}, "uint64", "u64", {"unsigned_", "int64"},
      "f32", "float32", "float", "f", "f64", "float64", "double", "d",
      "string", "s", "ref", "r", "type", "t", "true", "false", "null"};

   typedef struct packed {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [23:0] length;
      logic        last;
   } res_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic logic is_bin(input logic [7:0] c);
      return c == "0" || c == "1";
   endfunction

   function automatic logic id_first(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic id_rest(input logic [7:0] c);
      return id_first(c) || is_digit(c);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_e(input logic [7:0] c);
      return c == "e" || c == "E";
   endfunction

   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      logic [5:0] k;
      k = K_ERROR;
      case (c)
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "[": k = K_LBRACK;
         "]": k = K_RBRACK;
         "=": k = K_EQUALS;
         "*": k = K_STAR;
         ",": k = K_COMMA;
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/ddl_token_scanner_top.sv =====
`timescale 1ns / 1ps
// results of a byte are written into the registered queue when the byte transfers
// throughput, while rsp_ready is high: one byte per cycle while bytes give at most one
// token each; bytes giving two or three tokens drain one per cycle through a 4-entry queue
// reset (synchronous): scanner at token start, offset zero, queue empty,
// separator back to underscore; identifier buffer is not cleared
module ddl_token_scanner_top #(
   parameter int MAX_RESERVED_LEN = ddl_pkg::MaxReservedLen
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_stream_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_token_kind,
   output logic [23:0]           rsp_token_start,
   output logic [23:0]           rsp_token_length,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_wdata
);
   import ddl_pkg::*;

   localparam int IdxW = $clog2(MAX_RESERVED_LEN);

   typedef enum logic [4:0] {
      M_START, M_SLASH, M_LINE, M_BLOCK, M_NAME_FIRST, M_NAME_REST, M_CHAR,
      M_STRING, M_ZERO, M_HEX_FIRST, M_HEX, M_BIN_FIRST, M_BIN, M_OCT_FIRST,
      M_OCT, M_DOT_FIRST, M_INT, M_FRAC_START, M_FRAC, M_EXP_SIGN, M_EXP_FIRST,
      M_EXP, M_IDENT, M_HALT
   } mode_type;

   typedef struct packed {
      mode_type                        mode;
      logic [23:0]                     pos;
      logic [23:0]                     lstart;
      logic [23:0]                     llen;
      logic [3:0]                      flags;
      logic [MAX_RESERVED_LEN-1:0][7:0] ident;
   } st_type;

   typedef res_type [2:0] res_arr_type;

   st_type      st_ff, st_in, s;
   logic [7:0]  sep_ff;
   res_arr_type r;
   logic [1:0]  n;
   logic        end_f;
   logic        req_xfer;

   res_type     q_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff, cnt_in;

   function automatic void emit(input logic [5:0] k, input st_type st,
                                inout res_arr_type rr, inout logic [1:0] nn);
      if (nn != 2'd3) begin
         rr[nn] = '{kind: k, start: st.lstart, length: st.llen, last: 1'b0};
         nn = nn + 2'd1;
      end
   endfunction

   function automatic void take(inout st_type st);
      st.pos = st.pos + 24'd1;
      if (st.llen != LenMax) st.llen = st.llen + 24'd1;
   endfunction

   function automatic void lex_begin(inout st_type st);
      st.lstart = st.pos;
      st.llen = '0;
      st.flags = '0;
   endfunction

   function automatic void fail(inout st_type st, inout res_arr_type rr,
                                inout logic [1:0] nn);
      emit(K_ERROR, st, rr, nn);
      st.mode = M_HALT;
   endfunction

   function automatic logic [5:0] word_kind(input st_type st);
      logic [5:0] k;
      logic       m;
      k = K_IDENT;
      if (st.llen <= 24'(MAX_RESERVED_LEN)) begin
         for (int w = NumWords - 1; w >= 0; w--) begin
            m = (st.llen == 24'(WordLen[w]));
            for (int i = 0; i < WordBytes; i++) begin
               if (i < int'(WordLen[w]))
                  m = m && (st.ident[i] ==
                            WordText[w][8*(int'(WordLen[w])-1-i) +: 8]);
            end
            if (m) k = WordKind[w];
         end
      end
      return k;
   endfunction

   function automatic void start_token(input logic [7:0] c, inout st_type st,
                                       inout res_arr_type rr, inout logic [1:0] nn);
      st.mode = M_START;
      if (c == 8'd0) begin
         lex_begin(st);
         emit(K_EOF, st, rr, nn);
      end else if (is_space(c)) begin
         st.pos = st.pos + 24'd1;
      end else begin
         lex_begin(st);
         if (punct_kind(c) != K_ERROR) begin
            take(st);
            emit(punct_kind(c), st, rr, nn);
         end else if (c == "/") begin
            st.pos = st.pos + 24'd1;
            st.mode = M_SLASH;
         end else if (c == "$" || c == "%") begin
            take(st);
            st.mode = M_NAME_FIRST;
         end else if (c == "'") begin
            take(st);
            st.mode = M_CHAR;
         end else if (c == "\"") begin
            take(st);
            st.mode = M_STRING;
         end else if (is_digit(c) || c == ".") begin
            take(st);
            st.mode = (c == "0") ? M_ZERO : (c == ".") ? M_DOT_FIRST : M_INT;
         end else if (id_first(c)) begin
            st.ident[0] = c;
            take(st);
            st.mode = M_IDENT;
         end else begin
            fail(st, rr, nn);
         end
      end
   endfunction

   function automatic void feed(input logic [7:0] c, input logic [7:0] sep,
                                inout st_type st, inout res_arr_type rr,
                                inout logic [1:0] nn);
      logic tk, sp;
      tk = 1'b1;
      sp = (c != 8'd0) && (c == sep);
      // a leading zero without a radix letter carries on as a decimal
      if (st.mode == M_ZERO && !(c == "x" || c == "X" || c == "b" || c == "B" ||
                                 c == "o" || c == "O"))
         st.mode = M_INT;
      case (st.mode)
         M_START: start_token(c, st, rr, nn);
         M_SLASH: begin
            if (c == "/") begin
               st.pos = st.pos + 24'd1;
               st.mode = M_LINE;
            end else if (c == "*") begin
               st.pos = st.pos + 24'd1;
               st.mode = M_BLOCK;
               st.flags = '0;
            end else fail(st, rr, nn);
         end
         M_LINE: begin
            if (c == 8'd0) tk = 1'b0;
            else begin
               st.pos = st.pos + 24'd1;
               if (c == 8'd10) st.mode = M_START;
            end
         end
         M_BLOCK: begin
            if (c == 8'd0) tk = 1'b0;
            else begin
               st.pos = st.pos + 24'd1;
               if ((st.flags & F_STAR) != '0 && c == "/") st.mode = M_START;
               else st.flags = (c == "*") ? F_STAR : 4'd0;
            end
         end
         M_NAME_FIRST: begin
            if (id_first(c)) begin
               take(st);
               st.mode = M_NAME_REST;
            end else fail(st, rr, nn);
         end
         M_NAME_REST: begin
            if (id_rest(c)) take(st);
            else if (c == "%") begin
               take(st);
               st.flags = st.flags | F_PATH;
               st.mode = M_NAME_FIRST;
            end else begin
               emit(((st.flags & F_PATH) != '0) ? K_PATH : K_NAME, st, rr, nn);
               tk = 1'b0;
            end
         end
         M_CHAR, M_STRING: begin
            if (c == 8'd0) fail(st, rr, nn);
            else if ((st.flags & F_ESC) != '0) begin
               take(st);
               st.flags = st.flags & ~F_ESC;
            end else if (c == ((st.mode == M_CHAR) ? 8'h27 : 8'h22)) begin
               take(st);
               if (st.mode == M_CHAR && (st.flags & F_NONEMPTY) == '0)
                  fail(st, rr, nn);
               else begin
                  emit((st.mode == M_CHAR) ? K_CHAR : K_STRING, st, rr, nn);
                  st.mode = M_START;
               end
            end else begin
               st.flags = st.flags | F_NONEMPTY;
               if (c == "\\") st.flags = st.flags | F_ESC;
               take(st);
            end
         end
         M_ZERO: begin
            take(st);
            if (c == "x" || c == "X") st.mode = M_HEX_FIRST;
            else if (c == "b" || c == "B") st.mode = M_BIN_FIRST;
            else st.mode = M_OCT_FIRST;
         end
         M_HEX_FIRST: begin
            if (is_hex(c)) begin take(st); st.mode = M_HEX; end
            else fail(st, rr, nn);
         end
         M_BIN_FIRST: begin
            if (is_bin(c)) begin take(st); st.mode = M_BIN; end
            else fail(st, rr, nn);
         end
         M_OCT_FIRST: begin
            if (is_oct(c)) begin take(st); st.mode = M_OCT; end
            else fail(st, rr, nn);
         end
         M_HEX: begin
            if (is_hex(c) || sp) take(st);
            else begin emit(K_HEX, st, rr, nn); tk = 1'b0; end
         end
         M_BIN: begin
            if (is_bin(c) || sp) take(st);
            else begin emit(K_BIN, st, rr, nn); tk = 1'b0; end
         end
         M_OCT: begin
            if (is_oct(c) || sp) take(st);
            else begin emit(K_OCT, st, rr, nn); tk = 1'b0; end
         end
         M_DOT_FIRST: begin
            if (is_digit(c)) begin take(st); st.mode = M_FRAC; end
            else fail(st, rr, nn);
         end
         M_INT: begin
            if (is_digit(c) || sp) take(st);
            else if (c == ".") begin take(st); st.mode = M_FRAC_START; end
            else if (is_e(c)) begin take(st); st.mode = M_EXP_SIGN; end
            else begin emit(K_DEC, st, rr, nn); tk = 1'b0; end
         end
         M_FRAC_START: begin
            if (is_digit(c)) begin take(st); st.mode = M_FRAC; end
            else if (is_e(c)) begin take(st); st.mode = M_EXP_SIGN; end
            else begin emit(K_FLOAT, st, rr, nn); tk = 1'b0; end
         end
         M_FRAC: begin
            if (is_digit(c) || sp) take(st);
            else if (is_e(c)) begin take(st); st.mode = M_EXP_SIGN; end
            else begin emit(K_FLOAT, st, rr, nn); tk = 1'b0; end
         end
         M_EXP_SIGN: begin
            if (c == "+" || c == "-") begin take(st); st.mode = M_EXP_FIRST; end
            else if (is_digit(c)) begin take(st); st.mode = M_EXP; end
            else fail(st, rr, nn);
         end
         M_EXP_FIRST: begin
            if (is_digit(c)) begin take(st); st.mode = M_EXP; end
            else fail(st, rr, nn);
         end
         M_EXP: begin
            if (is_digit(c) || sp) take(st);
            else begin emit(K_FLOAT, st, rr, nn); tk = 1'b0; end
         end
         M_IDENT: begin
            if (id_rest(c)) begin
               if (st.llen < 24'(MAX_RESERVED_LEN)) st.ident[st.llen[IdxW-1:0]] = c;
               take(st);
            end else begin
               emit(word_kind(st), st, rr, nn);
               tk = 1'b0;
            end
         end
         M_HALT: tk = 1'b1;
         default: tk = 1'b0;
      endcase
      // the byte that ended a token starts the next one
      if (!tk) start_token(c, st, rr, nn);
   endfunction

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (cnt_ff <= 3'd1);
   assign csr_ready = 1'b1;
   assign end_f     = req_stream_end || (req_data_byte == 8'd0);

   always_comb begin
      s = st_ff;
      r = '0;
      n = 2'd0;
      if (s.mode != M_HALT) begin
         feed(req_data_byte, sep_ff, s, r, n);
         if (req_data_byte != 8'd0 && end_f) feed(8'd0, sep_ff, s, r, n);
      end
      if (end_f) begin
         s.mode   = M_START;
         s.pos    = '0;
         s.lstart = '0;
         s.llen   = '0;
         s.flags  = '0;
      end
      if (n != 2'd0) r[n - 2'd1].last = 1'b1;
      st_in = req_xfer ? s : st_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer) cnt_in = cnt_in + 3'(n);
      if (rsp_valid && rsp_ready) cnt_in = cnt_in - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode   <= M_START;
         st_ff.pos    <= '0;
         st_ff.lstart <= '0;
         st_ff.llen   <= '0;
         st_ff.flags  <= '0;
         sep_ff       <= SepReset;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         st_ff.mode   <= st_in.mode;
         st_ff.pos    <= st_in.pos;
         st_ff.lstart <= st_in.lstart;
         st_ff.llen   <= st_in.llen;
         st_ff.flags  <= st_in.flags;
         if (csr_valid && csr_ready) sep_ff <= csr_wdata;
         if (req_xfer) wp_ff <= wp_ff + n;
         if (rsp_valid && rsp_ready) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_in;
      end
      st_ff.ident <= st_in.ident;
      if (req_xfer) begin
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < n) q_ff[wp_ff + 2'(k)] <= r[k];
         end
      end
   end

   assign rsp_valid        = (cnt_ff != 3'd0);
   assign rsp_token_kind   = q_ff[rp_ff].kind;
   assign rsp_token_start  = q_ff[rp_ff].start;
   assign rsp_token_length = q_ff[rp_ff].length;
   assign rsp_last_of_run  = q_ff[rp_ff].last;

endmodule

// ===== rtl/ddl_token_scanner_chk.sv =====
`timescale 1ns / 1ps
`include "ddl_token_scanner_top_defines.svh"
module ddl_token_scanner_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_token_kind,
   input logic [23:0] rsp_token_length,
   input logic        rsp_last_of_run
);
   import ddl_pkg::*;

   `DDL_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result after reset")
   `DDL_ASSERT(a_kind_range, rsp_valid |-> rsp_token_kind <= K_LAST, "kind out of range")
   `DDL_ASSERT(a_eof_last, (rsp_valid && rsp_token_kind == K_EOF) |-> (rsp_token_length == 24'd0 && rsp_last_of_run), "bad eof")
   `DDL_ASSERT(a_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_token_kind)), "result dropped")
   `DDL_ASSERT(a_idle_ready, !rsp_valid |-> req_ready, "stalled while empty")

endmodule

bind ddl_token_scanner_top ddl_token_scanner_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_length (rsp_token_length),
   .rsp_last_of_run  (rsp_last_of_run)
);
